FILE: rtl/core/tevq_pkg.sv
// Package: constants and types shared by the timer event queue.
package tevq_pkg;
  localparam int unsigned EventSlots  = 16;
  localparam int unsigned SlotBits    = $clog2(EventSlots);
  localparam int unsigned CounterBits = 16;
  localparam int unsigned TickBits    = 32;
  localparam int unsigned DelayBits   = 15;
  localparam logic [DelayBits-1:0] MaxDelayReset = 15'd16383;

  localparam logic [1:0] ModeTime     = 2'd0;
  localparam logic [1:0] ModeSchedule = 2'd1;
  localparam logic [1:0] ModeCancel   = 2'd2;

  localparam logic KindExpired = 1'b0;
  localparam logic KindCompare = 1'b1;

  typedef logic [SlotBits-1:0] slot_t;
  typedef logic [TickBits-1:0] tick_t;

  // memory access request from the sequencer to the slot store
  typedef struct packed {
    logic  dl_we;
    slot_t dl_waddr;
    tick_t dl_wdata;
    slot_t dl_raddr;
    logic  nx_we;
    slot_t nx_waddr;
    slot_t nx_wdata;
    slot_t nx_raddr;
  } mem_req_t;
endpackage

FILE: rtl/core/timer_event_deadline_queue_unit.sv
// Top level: sorted timer event queue with APB config and sequenced list walks.
//
// Usage: pulse start with a transaction while busy is low. Each transaction
// extends the 32-bit tick from counter_sample_i, then schedules (mode 1) or
// cancels (mode 2) a slot in a deadline-sorted linked list, pops every expired
// slot (one valid_o strobe with kind 0 each) and ends with one compare value
// (kind 1, last 1). Each result is on the outputs for one cycle; the receiver
// cannot stall, so none are held back.
// Steps: a time transaction reads the queue head (StPopRd) and, on an empty
// queue, goes straight to the compare value (StCmp); otherwise each head is
// read and checked (StPopWt, StPopCmp) and popped while expired. Removal walks
// the list node by node (StRmRd, StRmWt); insertion writes the deadline
// (StInsWr), walks the nodes it passes (StInsRd, StInsWt) and links the slot
// (StInsCmp, plus StInsLnk after a predecessor); a schedule first reads the
// base deadline (StRef). The walk speed is set by the single read port of the link memory.
// One transaction is processed at a time; busy stays high until last is sent,
// and the next transaction can be accepted in the cycle after that.
// Reset empties the queue, clears the tick and sets max_delay to 16383;
// deadline and link memories need no clearing.
module timer_event_deadline_queue_unit import tevq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [15:0] counter_sample_i,
  input  logic [3:0]  event_id_i,
  input  logic [31:0] delay_i,
  input  logic        use_ref_i,
  input  logic [3:0]  ref_id_i,
  output logic        valid_o,
  output logic        kind_o,
  output logic [3:0]  expired_slot_o,
  output logic [15:0] compare_value_o,
  output logic        last_o
);
  typedef enum logic [14:0] {
    StIdle   = 15'b000000000000001,
    StRef    = 15'b000000000000010,
    StRmChk  = 15'b000000000000100,
    StRmRd   = 15'b000000000001000,
    StRmWt   = 15'b000000000010000,
    StInsWr  = 15'b000000000100000,
    StInsRd  = 15'b000000001000000,
    StInsWt  = 15'b000000010000000,
    StInsCmp = 15'b000000100000000,
    StInsLnk = 15'b000001000000000,
    StPopRd  = 15'b000010000000000,
    StPopWt  = 15'b000100000000000,
    StPopCmp = 15'b001000000000000,
    StCmp    = 15'b010000000000000,
    StSpare  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic [DelayBits-1:0] max_delay_q;
  tick_t tick_q, tick_d;
  logic [EventSlots-1:0] active_q, active_d;
  slot_t head_q, head_d;
  logic [1:0] mode_q;
  slot_t id_q, cur_q, cur_d, prev_q, prev_d, rm_q, rm_d;
  logic have_prev_q, have_prev_d;
  tick_t delay_q, new_dl_q, new_dl_d;
  logic use_ref_q;
  logic [SlotBits:0] cnt_q, cnt_d;
  mem_req_t req;
  tick_t dl_rdata;
  slot_t nx_rdata;
  tick_t diff;
  tick_t ins_diff;
  logic [CounterBits-1:0] low;
  logic [DelayBits-1:0] cmp_gap;

  tevq_store u_store (
    .clk_i      (clk_i),
    .req_i      (req),
    .dl_rdata_o (dl_rdata),
    .nx_rdata_o (nx_rdata)
  );

  assign pready = 1'b1;
  assign prdata = {{(32-DelayBits){1'b0}}, max_delay_q};
  assign busy   = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_delay_q <= MaxDelayReset;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      max_delay_q <= pwdata[DelayBits-1:0];
    end
  end

  always_comb begin
    tick_d = tick_q;
    if (start && !busy) begin
      tick_d = {tick_q[TickBits-1:CounterBits], counter_sample_i};
      if (counter_sample_i < tick_q[CounterBits-1:0]) begin
        tick_d = tick_d + (tick_t'(1) << CounterBits);
      end
    end
  end

  function automatic logic [SlotBits:0] popcnt(logic [EventSlots-1:0] v);
    logic [SlotBits:0] n;
    n = '0;
    for (int i = 0; i < EventSlots; i++) n = n + (SlotBits+1)'(v[i]);
    return n;
  endfunction

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    head_d      = head_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    rm_d        = rm_q;
    have_prev_d = have_prev_q;
    new_dl_d    = new_dl_q;
    cnt_d       = cnt_q;
    req         = '0;
    req.dl_raddr = cur_q;
    req.nx_raddr = cur_q;
    valid_o         = 1'b0;
    kind_o          = KindExpired;
    expired_slot_o  = '0;
    compare_value_o = '0;
    last_o          = 1'b0;
    diff     = dl_rdata - tick_q;
    ins_diff = new_dl_q - dl_rdata;
    cmp_gap  = max_delay_q;
    low      = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          if (mode_i == ModeSchedule) begin
            req.dl_raddr = ref_id_i;
            state_d = StRef;
          end else if (mode_i == ModeCancel) begin
            rm_d = event_id_i;
            state_d = StRmChk;
          end else begin
            cur_d = head_q;
            state_d = StPopRd;
          end
        end
      end
      StRef: begin
        new_dl_d = delay_q + (use_ref_q ? dl_rdata : tick_q);
        rm_d = id_q;
        state_d = StRmChk;
      end
      StRmChk: begin
        cur_d = head_q;
        have_prev_d = 1'b0;
        if (!active_q[rm_q]) begin
          state_d = (mode_q == ModeSchedule) ? StInsWr : StPopRd;
        end else begin
          state_d = StRmRd;
        end
      end
      StRmRd: begin
        state_d = StRmWt;
      end
      StRmWt: begin
        if (cur_q == rm_q) begin
          if (have_prev_q) begin
            req.nx_we = 1'b1;
            req.nx_waddr = prev_q;
            req.nx_wdata = nx_rdata;
          end else begin
            head_d = nx_rdata;
          end
          active_d[rm_q] = 1'b0;
          cur_d = have_prev_q ? head_q : nx_rdata;
          state_d = (mode_q == ModeSchedule) ? StInsWr : StPopRd;
        end else begin
          prev_d = cur_q;
          have_prev_d = 1'b1;
          cur_d = nx_rdata;
          state_d = StRmRd;
        end
      end
      StInsWr: begin
        req.dl_we = 1'b1;
        req.dl_waddr = id_q;
        req.dl_wdata = new_dl_q;
        have_prev_d = 1'b0;
        cnt_d = popcnt(active_q);
        state_d = (popcnt(active_q) == '0) ? StInsCmp : StInsRd;
      end
      StInsRd: begin
        state_d = StInsWt;
      end
      StInsWt: begin
        if (ins_diff[TickBits-1]) begin
          state_d = StInsCmp;
        end else begin
          prev_d = cur_q;
          have_prev_d = 1'b1;
          cur_d = nx_rdata;
          cnt_d = cnt_q - (SlotBits+1)'(1);
          state_d = (cnt_q == (SlotBits+1)'(1)) ? StInsCmp : StInsRd;
        end
      end
      StInsCmp: begin
        req.nx_we = 1'b1;
        req.nx_waddr = id_q;
        req.nx_wdata = (cnt_q != '0) ? cur_q : '0;
        if (!have_prev_q) begin
          head_d = id_q;
        end
        active_d[id_q] = 1'b1;
        state_d = have_prev_q ? StInsLnk : StPopRd;
      end
      StInsLnk: begin
        req.nx_we = 1'b1;
        req.nx_waddr = prev_q;
        req.nx_wdata = id_q;
        state_d = StPopRd;
      end
      StPopRd: begin
        cur_d = head_q;
        req.dl_raddr = head_q;
        req.nx_raddr = head_q;
        state_d = (active_q == '0) ? StCmp : StPopWt;
      end
      StPopWt: begin
        state_d = StPopCmp;
      end
      StPopCmp: begin
        if (diff[TickBits-1]) begin
          valid_o = 1'b1;
          expired_slot_o = head_q;
          head_d = nx_rdata;
          active_d[head_q] = 1'b0;
          state_d = StPopRd;
        end else begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        if (active_q != '0) begin
          if (diff < tick_t'(max_delay_q)) cmp_gap = diff[DelayBits-1:0];
        end
        low = tick_q[CounterBits-1:0] + CounterBits'(cmp_gap) + CounterBits'(1);
        valid_o = 1'b1;
        kind_o = KindCompare;
        compare_value_o = low;
        last_o = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    // StCmp reads head deadline registered in StPopCmp path
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tick_q      <= '0;
      active_q    <= '0;
      head_q      <= '0;
      have_prev_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      active_q    <= active_d;
      head_q      <= head_d;
      have_prev_q <= have_prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    rm_q     <= rm_d;
    new_dl_q <= new_dl_d;
    cnt_q    <= cnt_d;
    if (start && !busy) begin
      mode_q    <= mode_i;
      id_q      <= event_id_i;
      delay_q   <= delay_i;
      use_ref_q <= use_ref_i;
    end
  end

`ifndef SYNTHESIS
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> kind_o == KindCompare) else $error("last without compare");
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !busy) else $error("busy after last");
  a_pop_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o == KindExpired |-> active_q[expired_slot_o])
    else $error("popped inactive slot");
`endif
endmodule

FILE: rtl/core/tevq_store.sv
// Slot store: deadline and link memories with registered read data.
module tevq_store import tevq_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output tick_t    dl_rdata_o,
  output slot_t    nx_rdata_o
);
  tick_t dl_mem [EventSlots];
  slot_t nx_mem [EventSlots];

  always_ff @(posedge clk_i) begin
    if (req_i.dl_we) begin
      dl_mem[req_i.dl_waddr] <= req_i.dl_wdata;
    end
    dl_rdata_o <= dl_mem[req_i.dl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.nx_we) begin
      nx_mem[req_i.nx_waddr] <= req_i.nx_wdata;
    end
    nx_rdata_o <= nx_mem[req_i.nx_raddr];
  end
endmodule
